>>> hw/rtl/hhsd_pkg.sv
// Shared types and constants of the heavy-hitter and superspreader detector.
`timescale 1ns / 1ps
package hhsd_pkg;

    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF    = 4;
    localparam int DESTS_DEF   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int BUCKET_W    = 16;

    localparam logic [1:0] CFG_HEAVY  = 2'd0;
    localparam logic [1:0] CFG_SPREAD = 2'd1;
    localparam logic [1:0] CFG_EPOCH  = 2'd2;

    localparam logic [31:0] HEAVY_RST  = 32'd1000000;
    localparam logic [4:0]  SPREAD_RST = 5'd8;
    localparam logic [31:0] EPOCH_RST  = 32'd1000000;

    typedef struct packed {
        logic [31:0]         epoch;
        logic [BUCKET_W-1:0] bucket;
        logic [31:0]         src;
        logic [31:0]         dst;
        logic [15:0]         pay;
    } qitem_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] epoch;
        logic [31:0] source;
        logic [31:0] bytes;
        logic [31:0] packets;
        logic [1:0]  marks;
        logic [4:0]  count;
    } entry_t;

    typedef struct packed {
        logic [31:0] epoch;
        logic        hh;
        logic [31:0] bytes;
        logic [31:0] packets;
        logic        ss;
        logic [4:0]  dests;
        logic        full;
    } result_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

>>> hw/rtl/hhsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hhsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/hhsd_queue.sv
// Small register queue between the front and back parts.
`timescale 1ns / 1ps
module hhsd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= din;
        end
    end

endmodule

>>> hw/rtl/hhsd_front.sv
// Front part: accepts packet records, works out the epoch and the bucket.
`timescale 1ns / 1ps
module hhsd_front #(
    parameter int BUCKETS = hhsd_pkg::BUCKETS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [63:0]           ts,
    input  logic [31:0]           src,
    input  logic [31:0]           dst,
    input  logic [15:0]           pay,
    input  logic [31:0]           epoch_len,
    input  hhsd_pkg::back_status_t status,
    input  logic                  q_full,
    output logic                  q_push,
    output hhsd_pkg::qitem_t      q_item
);

    localparam int BW        = $clog2(BUCKETS);
    localparam int DIV_STEPS = 16;
    localparam logic [31:0] BK    = 32'(BUCKETS);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SUB  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]    st_reg, st_next;
    logic          started_reg;
    logic [63:0]   start_reg;
    logic [31:0]   cur_epoch_reg;
    logic [63:0]   ts_reg;
    logic [31:0]   src_reg, dst_reg;
    logic [15:0]   pay_reg;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   dl_reg, dl_next;
    logic [31:0]   q_reg, q_next;
    logic [63:0]   bprod_reg;
    logic [31:0]   brest_reg;
    logic [BW-1:0] brem_reg;
    logic          sat_reg;
    logic [3:0]    cnt_reg;
    logic [31:0]   len;
    logic [63:0]   elapsed;
    logic [31:0]   e32, new_epoch;
    logic          accept;

    assign len     = (epoch_len == '0) ? 32'd1 : epoch_len;
    assign s_ready = (st_reg == F_IDLE) && !status.clearing;
    assign accept  = s_valid && s_ready;
    assign elapsed = (ts_reg >= start_reg) ? ts_reg - start_reg : '0;
    assign e32       = sat_reg ? '1 : q_reg;
    assign new_epoch = (e32 > cur_epoch_reg) ? e32 : cur_epoch_reg;
    assign q_push    = (st_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_item.epoch  = new_epoch;
        q_item.bucket = hhsd_pkg::BUCKET_W'(brem_reg);
        q_item.src    = src_reg;
        q_item.dst    = dst_reg;
        q_item.pay    = pay_reg;
    end

    // Two quotient bits of the epoch per cycle.
    always_comb
    begin
        logic [32:0] t;
        rem_next  = rem_reg;
        dl_next   = dl_reg;
        q_next    = q_reg;
        for (int k = 0; k < 2; k++)
        begin
            t = {rem_next, dl_next[31]};
            if (t >= {1'b0, len})
            begin
                t        = t - {1'b0, len};
                q_next   = {q_next[30:0], 1'b1};
            end
            else
            begin
                q_next   = {q_next[30:0], 1'b0};
            end
            rem_next = t[31:0];
            dl_next  = {dl_next[30:0], 1'b0};
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            F_IDLE:  if (accept) st_next = F_SUB;
            F_SUB:   st_next = F_DIV;
            F_DIV:   if (cnt_reg == 4'(DIV_STEPS - 1)) st_next = F_PUSH;
            F_PUSH:  if (q_push) st_next = F_IDLE;
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= F_IDLE;
            started_reg   <= 1'b0;
            start_reg     <= '0;
            cur_epoch_reg <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (accept && !started_reg)
            begin
                started_reg <= 1'b1;
                start_reg   <= ts;
            end
            if (st_reg == F_SUB)
            begin
                cnt_reg <= '0;
            end
            else if (st_reg == F_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (q_push)
            begin
                cur_epoch_reg <= new_epoch;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg  <= ts;
            src_reg <= src;
            dst_reg <= dst;
            pay_reg <= pay;
        end
        if (st_reg == F_SUB)
        begin
            // A quotient of 2^32 or more shows when the high half already reaches the divisor.
            sat_reg   <= (elapsed[63:32] >= len);
            rem_reg   <= elapsed[63:32];
            dl_reg    <= elapsed[31:0];
            q_reg     <= '0;
            bprod_reg <= 64'(src_reg) * 64'(RECIP);
        end
        else if (st_reg == F_DIV)
        begin
            rem_reg  <= rem_next;
            dl_reg   <= dl_next;
            q_reg    <= q_next;
            // The reciprocal estimate of the bucket quotient is low by at most one,
            // so one conditional subtract finishes the remainder.
            if (cnt_reg == 4'd0)
            begin
                brest_reg <= src_reg - bprod_reg[63:32] * BK;
            end
            if (cnt_reg == 4'd1)
            begin
                brem_reg <= BW'((brest_reg >= BK) ? brest_reg - BK : brest_reg);
            end
        end
    end

endmodule

>>> hw/rtl/hhsd_back.sv
// Back part: searches the source table, updates counts and destinations, drives results.
`timescale 1ns / 1ps
module hhsd_back #(
    parameter int BUCKETS = hhsd_pkg::BUCKETS_DEF,
    parameter int WAYS    = hhsd_pkg::WAYS_DEF,
    parameter int DESTS   = hhsd_pkg::DESTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hhsd_pkg::qitem_t       q_item,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  logic [31:0]            heavy_limit,
    input  logic [4:0]             spread_limit,
    output hhsd_pkg::back_status_t status,
    output hhsd_pkg::result_t      m_res,
    output logic                   m_valid,
    input  logic                   m_ready
);

    localparam int ENTRIES  = BUCKETS * WAYS;
    localparam int SW       = $clog2(ENTRIES);
    localparam int DW       = $clog2(ENTRIES * DESTS);
    localparam int WCW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DIW      = $clog2(DESTS);
    localparam int DEST_CAP = (DESTS < 31) ? DESTS : 31;

    localparam logic [3:0] B_CLEAR = 4'd0;
    localparam logic [3:0] B_IDLE  = 4'd1;
    localparam logic [3:0] B_SRD   = 4'd2;
    localparam logic [3:0] B_SCHK  = 4'd3;
    localparam logic [3:0] B_DBASE = 4'd4;
    localparam logic [3:0] B_DRD   = 4'd5;
    localparam logic [3:0] B_DCHK  = 4'd6;
    localparam logic [3:0] B_UPD   = 4'd7;
    localparam logic [3:0] B_OUT   = 4'd8;

    logic [3:0]        st_reg;
    logic [SW-1:0]     clr_reg;
    hhsd_pkg::qitem_t  item_reg;
    logic [SW-1:0]     base_reg;
    logic [WCW-1:0]    way_reg;
    logic              hit_reg, free_reg, found_reg;
    logic [SW-1:0]     slot_reg;
    hhsd_pkg::entry_t  ent_reg;
    logic [DW-1:0]     dbase_reg;
    logic [DIW-1:0]    di_reg;
    hhsd_pkg::result_t res_reg, res_next;
    hhsd_pkg::result_t out_reg;
    logic              out_valid_reg;

    logic              e_we;
    logic [SW-1:0]     e_waddr, e_raddr;
    hhsd_pkg::entry_t  e_wdata, e_rdata;
    logic              d_we;
    logic [DW-1:0]     d_waddr, d_raddr;
    logic [31:0]       d_rdata;

    logic              ent_live, ent_match, last_way, add_dest, out_load;
    logic [32:0]       bsum;
    logic [31:0]       nb, np;
    logic [4:0]        nc;
    logic [1:0]        nm;
    logic              hh, ss;

    assign e_raddr   = base_reg + SW'(way_reg);
    assign ent_live  = e_rdata.valid && (e_rdata.epoch == item_reg.epoch);
    assign ent_match = ent_live && (e_rdata.source == item_reg.src);
    assign last_way  = (way_reg == WCW'(WAYS - 1));
    assign d_raddr   = dbase_reg + DW'(di_reg);
    assign add_dest  = hit_reg && !found_reg && (ent_reg.count < 5'(DEST_CAP));
    assign q_pop     = (st_reg == B_IDLE) && q_valid;
    assign out_load  = (st_reg == B_OUT) && (!out_valid_reg || m_ready);
    assign status.clearing = (st_reg == B_CLEAR);
    assign m_res     = out_reg;
    assign m_valid   = out_valid_reg;

    // New counts of the entry, and the report flags that the counts raise.
    always_comb
    begin
        bsum = {1'b0, ent_reg.bytes} + 33'(item_reg.pay);
        if (hit_reg)
        begin
            nb = bsum[32] ? '1 : bsum[31:0];
            np = (ent_reg.packets == '1) ? '1 : ent_reg.packets + 32'd1;
            nc = add_dest ? ent_reg.count + 5'd1 : ent_reg.count;
            nm = ent_reg.marks;
        end
        else
        begin
            nb = 32'(item_reg.pay);
            np = 32'd1;
            nc = 5'd1;
            nm = 2'b00;
        end
        hh = (nb > heavy_limit) && !nm[0];
        ss = (nc > spread_limit) && !nm[1];
    end

    always_comb
    begin
        e_we    = (st_reg == B_CLEAR) || (st_reg == B_UPD);
        e_waddr = (st_reg == B_CLEAR) ? clr_reg : slot_reg;
        e_wdata = '0;
        if (st_reg == B_UPD)
        begin
            e_wdata.valid   = 1'b1;
            e_wdata.epoch   = item_reg.epoch;
            e_wdata.source  = item_reg.src;
            e_wdata.bytes   = nb;
            e_wdata.packets = np;
            e_wdata.marks   = nm | {ss, hh};
            e_wdata.count   = nc;
        end
        d_we    = (st_reg == B_UPD) && (!hit_reg || add_dest);
        d_waddr = hit_reg ? dbase_reg + DW'(ent_reg.count) : dbase_reg;
    end

    always_comb
    begin
        res_next         = res_reg;
        res_next.epoch   = item_reg.epoch;
        if (st_reg == B_UPD)
        begin
            res_next.hh      = hh;
            res_next.bytes   = nb;
            res_next.packets = np;
            res_next.ss      = ss;
            res_next.dests   = nc;
            res_next.full    = 1'b0;
        end
        else if ((st_reg == B_SCHK) && last_way && !ent_match && ent_live && !free_reg)
        begin
            res_next.hh      = 1'b0;
            res_next.bytes   = '0;
            res_next.packets = '0;
            res_next.ss      = 1'b0;
            res_next.dests   = '0;
            res_next.full    = 1'b1;
        end
    end

    hhsd_ram #(
        .WIDTH ($bits(hhsd_pkg::entry_t)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    hhsd_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES * DESTS)
    ) u_dest_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (item_reg.dst),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SW'(ENTRIES - 1))
                    begin
                        st_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        st_reg <= B_SRD;
                    end
                end
                B_SRD:
                begin
                    st_reg <= B_SCHK;
                end
                B_SCHK:
                begin
                    if (ent_match)
                    begin
                        st_reg <= B_DBASE;
                    end
                    else if (last_way)
                    begin
                        st_reg <= (free_reg || !ent_live) ? B_DBASE : B_OUT;
                    end
                    else
                    begin
                        st_reg <= B_SRD;
                    end
                end
                B_DBASE:
                begin
                    st_reg <= (hit_reg && ent_reg.count != '0) ? B_DRD : B_UPD;
                end
                B_DRD:
                begin
                    st_reg <= B_DCHK;
                end
                B_DCHK:
                begin
                    if ((d_rdata == item_reg.dst) ||
                        ((32'(di_reg) + 32'd1) == 32'(ent_reg.count)))
                    begin
                        st_reg <= B_UPD;
                    end
                    else
                    begin
                        st_reg <= B_DRD;
                    end
                end
                B_UPD:
                begin
                    st_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_load)
                    begin
                        st_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        if (q_pop)
        begin
            item_reg <= q_item;
            base_reg <= SW'(32'(q_item.bucket) * 32'(WAYS));
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        if (st_reg == B_SCHK)
        begin
            if (ent_match)
            begin
                hit_reg  <= 1'b1;
                slot_reg <= e_raddr;
                ent_reg  <= e_rdata;
            end
            else
            begin
                // The lowest free way is the one kept for a new source.
                if (!ent_live && !free_reg)
                begin
                    free_reg <= 1'b1;
                    slot_reg <= e_raddr;
                end
                way_reg <= way_reg + 1'b1;
            end
        end
        if (st_reg == B_DBASE)
        begin
            dbase_reg <= DW'(32'(slot_reg) * 32'(DESTS));
            di_reg    <= '0;
            found_reg <= 1'b0;
        end
        if (st_reg == B_DCHK)
        begin
            if (d_rdata == item_reg.dst)
            begin
                found_reg <= 1'b1;
            end
            di_reg <= di_reg + 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.full |->
            !out_reg.hh && !out_reg.ss && out_reg.bytes == '0 && out_reg.dests == '0)
        else $error("full-bucket result carries nonzero counts");
    a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.full |-> out_reg.packets != '0 && out_reg.dests != '0)
        else $error("recorded source shows zero packets or destinations");
    a_dest_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.dests <= 5'(DEST_CAP))
        else $error("destination count beyond its cap");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == B_CLEAR |-> !q_pop)
        else $error("request taken during table clear");
`endif

endmodule

>>> hw/rtl/heavy_hitter_superspreader_detector.sv
// Top level of the heavy-hitter and superspreader detector.
//
// Channel   Direction  Handshake            Content
// s_axis    in         s_tvalid / s_tready  packet record
// m_axis    out        m_tvalid / m_tready  per-packet result
// cfg       in         cfg_we               register write
//
// After reset the source table of BUCKETS*WAYS entries (4096 by default) is
// cleared while s_tready stays low. The front takes one request at a time, its
// pace bounded by its two-bit-per-cycle epoch divider. The back checks each way
// searched in turn, then compares the stored destinations in turn, each step
// paced by the registered read of the table RAMs, then updates the entry; a
// full bucket skips the update. The two-entry queue and the output register
// let either side stall without holding up the other until they fill.
`timescale 1ns / 1ps
module heavy_hitter_superspreader_detector #(
    parameter int BUCKETS = hhsd_pkg::BUCKETS_DEF,
    parameter int WAYS    = hhsd_pkg::WAYS_DEF,
    parameter int DESTS   = hhsd_pkg::DESTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // timestamp_us[63:0], src_addr[95:64], dst_addr[127:96], payload_bytes[143:128]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // epoch_number[31:0], heavy_hitter[32], source_bytes[64:33],
    // source_packets[96:65], superspreader[97], distinct_dests[102:98], table_full[103]
    output logic [103:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [31:0] heavy_reg;
    logic [4:0]  spread_reg;
    logic [31:0] epoch_len_reg;

    hhsd_pkg::back_status_t status;
    hhsd_pkg::qitem_t       f_item, b_item;
    hhsd_pkg::result_t      res;
    logic                   q_push, q_full, q_pop, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heavy_reg     <= hhsd_pkg::HEAVY_RST;
            spread_reg    <= hhsd_pkg::SPREAD_RST;
            epoch_len_reg <= hhsd_pkg::EPOCH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hhsd_pkg::CFG_HEAVY:  heavy_reg     <= cfg_data;
                hhsd_pkg::CFG_SPREAD: spread_reg    <= cfg_data[4:0];
                hhsd_pkg::CFG_EPOCH:  epoch_len_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    hhsd_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .ts        (s_tdata[63:0]),
        .src       (s_tdata[95:64]),
        .dst       (s_tdata[127:96]),
        .pay       (s_tdata[143:128]),
        .epoch_len (epoch_len_reg),
        .status    (status),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (f_item)
    );

    hhsd_queue #(
        .WIDTH ($bits(hhsd_pkg::qitem_t)),
        .DEPTH (hhsd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (f_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (b_item),
        .empty (q_empty)
    );

    hhsd_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .DESTS   (DESTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (b_item),
        .q_valid      (!q_empty),
        .q_pop        (q_pop),
        .heavy_limit  (heavy_reg),
        .spread_limit (spread_reg),
        .status       (status),
        .m_res        (res),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready)
    );

    assign m_tdata = {res.full, res.dests, res.ss, res.packets, res.bytes, res.hh, res.epoch};

endmodule

>>> verif/testbench.sv
// Self-checking testbench of the heavy-hitter and superspreader detector.
`timescale 1ns / 1ps
module testbench;

    localparam int NBUCKETS    = hhsd_pkg::BUCKETS_DEF;
    localparam int NWAYS       = hhsd_pkg::WAYS_DEF;
    localparam int NDESTS      = hhsd_pkg::DESTS_DEF;
    localparam int NENTRIES    = NBUCKETS * NWAYS;
    localparam int DEST_LIMIT  = (NDESTS < 31) ? NDESTS : 31;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 300;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    class detector_scoreboard;
        typedef struct {
            bit [31:0] epoch;
            bit        hh;
            bit [31:0] bytes;
            bit [31:0] packets;
            bit        ss;
            bit [4:0]  dests;
            bit        full;
        } report_t;

        report_t   expected_q[$];
        int        errors = 0;
        bit [31:0] heavy_limit = hhsd_pkg::HEAVY_RST;
        bit [4:0]  spread_lim  = hhsd_pkg::SPREAD_RST;
        bit [31:0] epoch_len   = hhsd_pkg::EPOCH_RST;
        bit        started = 0;
        bit [63:0] first_ts = 0;
        bit [31:0] epoch_now = 0;
        bit        ent_valid[NENTRIES];
        bit [31:0] ent_src[NENTRIES];
        bit [31:0] ent_bytes[NENTRIES];
        bit [31:0] ent_pkts[NENTRIES];
        bit [1:0]  ent_marks[NENTRIES];
        bit [4:0]  ent_count[NENTRIES];
        bit [31:0] ent_dst[NENTRIES * NDESTS];

        function void write_reg(bit [1:0] idx, bit [31:0] val);
            case (idx)
                hhsd_pkg::CFG_HEAVY:  heavy_limit = val;
                hhsd_pkg::CFG_SPREAD: spread_lim = val[4:0];
                hhsd_pkg::CFG_EPOCH:  epoch_len = val;
                default: ;
            endcase
        endfunction

        function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void note_packet(bit [63:0] ts, bit [31:0] src, bit [31:0] dst,
                                  bit [15:0] pay);
            bit [63:0] span;
            bit [63:0] elapsed;
            bit [63:0] quot;
            bit [31:0] e32;
            int        base;
            int        slot;
            int        free_slot;
            bit        hit;
            bit        have_free;
            bit        seen;
            report_t   r;
            if (!started)
            begin
                started = 1;
                first_ts = ts;
                epoch_now = 0;
            end
            span = (epoch_len == 0) ? 64'd1 : {32'd0, epoch_len};
            elapsed = (ts >= first_ts) ? ts - first_ts : 64'd0;
            quot = elapsed / span;
            e32 = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
            if (e32 > epoch_now)
            begin
                epoch_now = e32;
                foreach (ent_valid[i]) ent_valid[i] = 0;
            end
            base = int'(src % NBUCKETS) * NWAYS;
            hit = 0;
            have_free = 0;
            slot = 0;
            free_slot = 0;
            for (int w = 0; w < NWAYS; w++)
            begin
                if (ent_valid[base + w])
                begin
                    if (!hit && ent_src[base + w] == src)
                    begin
                        hit = 1;
                        slot = base + w;
                    end
                end
                else if (!have_free)
                begin
                    have_free = 1;
                    free_slot = base + w;
                end
            end
            r = '{epoch: epoch_now, hh: 0, bytes: 0, packets: 0, ss: 0, dests: 0, full: 0};
            if (!hit && !have_free)
            begin
                r.full = 1;
            end
            else
            begin
                if (hit)
                begin
                    ent_bytes[slot] = sat_add(ent_bytes[slot], 32'(pay));
                    ent_pkts[slot] = sat_add(ent_pkts[slot], 32'd1);
                    seen = 0;
                    for (int i = 0; i < ent_count[slot]; i++)
                        if (ent_dst[slot * NDESTS + i] == dst) seen = 1;
                    if (!seen && ent_count[slot] < DEST_LIMIT)
                    begin
                        ent_dst[slot * NDESTS + ent_count[slot]] = dst;
                        ent_count[slot] = ent_count[slot] + 5'd1;
                    end
                end
                else
                begin
                    slot = free_slot;
                    ent_valid[slot] = 1;
                    ent_src[slot] = src;
                    ent_bytes[slot] = 32'(pay);
                    ent_pkts[slot] = 32'd1;
                    ent_marks[slot] = 2'b00;
                    ent_dst[slot * NDESTS] = dst;
                    ent_count[slot] = 5'd1;
                end
                if (ent_bytes[slot] > heavy_limit && !ent_marks[slot][0])
                begin
                    r.hh = 1;
                    ent_marks[slot][0] = 1;
                end
                if (ent_count[slot] > spread_lim && !ent_marks[slot][1])
                begin
                    r.ss = 1;
                    ent_marks[slot][1] = 1;
                end
                r.bytes = ent_bytes[slot];
                r.packets = ent_pkts[slot];
                r.dests = ent_count[slot];
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(bit [103:0] d);
            report_t got;
            report_t want;
            got.epoch = d[31:0];
            got.hh = d[32];
            got.bytes = d[64:33];
            got.packets = d[96:65];
            got.ss = d[97];
            got.dests = d[102:98];
            got.full = d[103];
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result %h", d);
                return;
            end
            want = expected_q.pop_front();
            if (got.epoch !== want.epoch || got.hh !== want.hh || got.bytes !== want.bytes ||
                got.packets !== want.packets || got.ss !== want.ss ||
                got.dests !== want.dests || got.full !== want.full)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: expected epoch=%0d hh=%0d bytes=%0d pkts=%0d",
                             want.epoch, want.hh, want.bytes, want.packets);
                    $display("       ss=%0d dests=%0d full=%0d",
                             want.ss, want.dests, want.full);
                    $display("       got epoch=%0d hh=%0d bytes=%0d pkts=%0d",
                             got.epoch, got.hh, got.bytes, got.packets);
                    $display("       ss=%0d dests=%0d full=%0d",
                             got.ss, got.dests, got.full);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    detector_scoreboard board = new();
    bit        send_burst = 0;
    bit        recv_burst = 0;
    bit        hold_request = 0;
    int        quiet_cycles = 0;
    bit [63:0] now_ts = 64'd100;
    bit [21:0] src_high[4][6];
    bit [9:0]  hot_bucket[4];
    bit [31:0] dst_pool[20];

    heavy_hitter_superspreader_detector DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic send_packet(bit [63:0] ts, bit [31:0] src, bit [31:0] dst, bit [15:0] pay);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {pay, dst, src, ts};
        do @(posedge clk); while (!s_tready);
        board.note_packet(ts, src, dst, pay);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        s_tvalid <= 0;
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly forward time steps inside one epoch, with occasional epoch jumps
    // and occasional records that go back in time; with wild_time set, all times are random.
    task automatic random_packets(int count, bit [31:0] len, bit wild_time);
        bit [63:0] span;
        bit [63:0] ts;
        bit [31:0] src;
        bit [31:0] dst;
        bit [15:0] pay;
        int        b;
        span = (len == 0) ? 64'd1 : {32'd0, len};
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
            if (wild_time)
            begin
                ts = {$urandom, $urandom};
            end
            else if ($urandom_range(0, 31) == 0)
            begin
                ts = now_ts - 64'($urandom_range(0, 5000));
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    now_ts = now_ts + span * 64'($urandom_range(1, 3));
                else
                    now_ts = now_ts + span / 8 * 64'($urandom_range(0, 100)) / 100;
                ts = now_ts;
            end
            b = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                src = $urandom;
            else
                src = {src_high[b][$urandom_range(0, 5)], hot_bucket[b]};
            dst = ($urandom_range(0, 3) == 0) ? $urandom : dst_pool[$urandom_range(0, 19)];
            case ($urandom_range(0, 7))
                0: pay = 16'hFFFF;
                1: pay = 16'($urandom);
                default: pay = 16'($urandom_range(0, 1500));
            endcase
            send_packet(ts, src, dst, pay);
        end
        send_burst = 0;
    endtask

    // Receiver: random gaps, stretches without gaps, and one long hold-off.
    initial
    begin
        int gap;
        m_tready = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0) recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 3);
            if (hold_request)
            begin
                hold_request = 0;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
            board.check_result(m_tdata);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        s_tvalid = 0;
        s_tdata = '0;
        cfg_we = 0;
        cfg_index = hhsd_pkg::CFG_HEAVY;
        cfg_data = '0;
        rst_n = 0;
        foreach (hot_bucket[i]) hot_bucket[i] = 10'($urandom);
        foreach (src_high[i, j]) src_high[i][j] = 22'($urandom);
        foreach (dst_pool[i]) dst_pool[i] = $urandom;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_reg(hhsd_pkg::CFG_HEAVY, 32'd3000);
        write_reg(hhsd_pkg::CFG_SPREAD, 32'd3);
        write_reg(hhsd_pkg::CFG_EPOCH, 32'd1000);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);

        // Field extremes, then one source crossing the byte limit only once.
        send_packet(64'd100, 32'd0, 32'd0, 16'd0);
        send_packet(64'd100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_packet(64'd101, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        // One source fanning out past the spread limit and the stored set.
        for (int i = 0; i < 18; i++)
            send_packet(64'd102, 32'd5, 32'h0A00_0000 + 32'(i), 16'd40);
        // Five sources in one bucket: the last one finds it full.
        for (int k = 0; k < 5; k++)
            send_packet(64'd103, 32'd7 + 32'(k * NBUCKETS), 32'd9, 16'd60);
        // A record from the past keeps the epoch, a later one moves it on.
        send_packet(64'd50, 32'd7, 32'd9, 16'd60);
        now_ts = 64'd5100;
        send_packet(now_ts, 32'd7, 32'd9, 16'd60);
        wait_drained();

        write_reg(hhsd_pkg::CFG_HEAVY, 32'd0);
        write_reg(hhsd_pkg::CFG_SPREAD, 32'd0);
        write_reg(hhsd_pkg::CFG_EPOCH, 32'd0);
        random_packets(300, 32'd0, 0);
        wait_drained();

        write_reg(hhsd_pkg::CFG_HEAVY, 32'd20000);
        write_reg(hhsd_pkg::CFG_SPREAD, 32'd16);
        write_reg(hhsd_pkg::CFG_EPOCH, 32'd5000);
        random_packets(100, 32'd5000, 0);
        hold_request = 1;
        random_packets(200, 32'd5000, 0);
        wait_drained();

        write_reg(hhsd_pkg::CFG_HEAVY, 32'hFFFF_FFFF);
        write_reg(hhsd_pkg::CFG_SPREAD, 32'd5);
        write_reg(hhsd_pkg::CFG_EPOCH, 32'd100000);
        random_packets(300, 32'd100000, 0);
        wait_drained();

        write_reg(hhsd_pkg::CFG_HEAVY, 32'd50000);
        write_reg(hhsd_pkg::CFG_SPREAD, 32'd1);
        write_reg(hhsd_pkg::CFG_EPOCH, 32'hFFFF_FFFF);
        random_packets(200, 32'hFFFF_FFFF, 1);
        wait_drained();

        // Tiny epochs with huge times push the epoch index past 32 bits.
        write_reg(hhsd_pkg::CFG_EPOCH, 32'd1);
        send_packet(64'hFFFF_FFFF_FFFF_FFFF, 32'd11, 32'd12, 16'd10);
        random_packets(30, 32'd1, 1);
        wait_drained();
        repeat (100) @(posedge clk);

        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/hhsd_pkg.sv
hw/rtl/hhsd_ram.sv
hw/rtl/hhsd_queue.sv
hw/rtl/hhsd_front.sv
hw/rtl/hhsd_back.sv
hw/rtl/heavy_hitter_superspreader_detector.sv
verif/testbench.sv
